// ===== sv/vbds_pkg.sv =====
// Package for the volume box downsample unit.
// Holds configuration register indexes, field widths, default parameters and the state type.
// No dependencies.
package vbds_pkg;

	localparam int unsigned MaxDimDefault = 128;
	localparam int unsigned SampleBitsDefault = 24;
	localparam int unsigned MaxZoomDefault = 8;
	localparam int unsigned CfgIndexBits = 3;
	localparam int unsigned CfgDataBits = 12;

	localparam logic [CfgIndexBits-1:0] REG_SRC_X = 3'd0;
	localparam logic [CfgIndexBits-1:0] REG_SRC_Y = 3'd1;
	localparam logic [CfgIndexBits-1:0] REG_SRC_Z = 3'd2;
	localparam logic [CfgIndexBits-1:0] REG_DST_X = 3'd3;
	localparam logic [CfgIndexBits-1:0] REG_DST_Y = 3'd4;
	localparam logic [CfgIndexBits-1:0] REG_DST_Z = 3'd5;
	localparam logic [CfgIndexBits-1:0] REG_ZOOM  = 3'd6;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

// ===== sv/vbds_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module vbds_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

// ===== sv/volume_box_downsample_unit.sv =====
// A box-completing request goes from acceptance through the read state, the divider
// and the output state; an error result is raised at acceptance. Requests are taken
// only in idle with no result pending, a completing box blocking them until its result
// is taken. The box sums live in one RAM read at acceptance, written back next.
// Reset (arst_n low) restores the register defaults and the origin position;
// the sum RAM is not cleared since the first voxel of a box overwrites it. Uses vbds_pkg.
module volume_box_downsample_unit #(
	parameter int unsigned MaxDim = vbds_pkg::MaxDimDefault,
	parameter int unsigned SampleBits = vbds_pkg::SampleBitsDefault,
	parameter int unsigned MaxZoom = vbds_pkg::MaxZoomDefault
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// [SampleBits-1:0] sample, zero fill to bytes
	input  logic [((SampleBits+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// [SampleBits-1:0] average, zero fill to bytes
	output logic [((SampleBits+7)/8)*8-1:0] m_axis_tdata,
	output logic m_axis_tlast,
	// [0] config_error
	output logic m_axis_tuser,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [vbds_pkg::CfgIndexBits-1:0] cfg_index,
	input  logic [vbds_pkg::CfgDataBits-1:0] cfg_data
);
	import vbds_pkg::*;

	localparam int unsigned PosBits = $clog2(MaxDim);
	localparam int unsigned AddrBits = 2 * PosBits;
	localparam int unsigned TdBits = ((SampleBits + 7) / 8) * 8;
	localparam int unsigned SumBits = SampleBits + $clog2(MaxZoom * MaxZoom * MaxZoom) + 1;
	localparam int unsigned DivBits = $clog2(MaxZoom * MaxZoom * MaxZoom + 1);
	localparam int unsigned DivSteps = SumBits;
	localparam int unsigned DivCntBits = $clog2(DivSteps + 1);

	logic [7:0] src_x_q, src_y_q, src_z_q, dst_x_q, dst_y_q, dst_z_q;
	logic [11:0] zoom_q;
	logic [PosBits-1:0] pos_x_q, pos_y_q, pos_z_q;
	logic [3:0] rx_q, ry_q, rz_q;
	logic [PosBits-1:0] bx_q, by_q, bz_q;
	state_t state_q, state_d;

	logic [3:0] zx, zy, zz;
	assign zx = zoom_q[3:0];
	assign zy = zoom_q[7:4];
	assign zz = zoom_q[11:8];

	logic err_q;
	logic [SampleBits-1:0] sample_s1;
	logic first_s1, last_s1, inside_s1, vol_last_s1;
	logic [AddrBits-1:0] addr_s1, rd_addr;
	logic [SumBits-1:0] rd_sum, new_sum;
	logic [SumBits-1:0] rem_q, quo_q;
	logic [DivBits-1:0] div_q;
	logic neg_q;
	logic [DivCntBits-1:0] cnt_q;
	logic [SampleBits-1:0] avg_q;
	logic tlast_q, tuser_q;

	function automatic logic size_bad(input logic [7:0] n);
		return n == 8'd0 || 32'(n) > MaxDim;
	endfunction
	function automatic logic zoom_bad(input logic [3:0] z);
		return z == 4'd0 || 32'(z) > MaxZoom;
	endfunction

	// Configuration check, registered; registers change only while idle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= 1'b0;
		end else begin
			err_q <= size_bad(src_x_q) || size_bad(src_y_q) || size_bad(src_z_q)
				|| size_bad(dst_x_q) || size_bad(dst_y_q) || size_bad(dst_z_q)
				|| zoom_bad(zx) || zoom_bad(zy) || zoom_bad(zz)
				|| (12'(dst_x_q) * 12'(zx) > 12'(src_x_q))
				|| (12'(dst_y_q) * 12'(zy) > 12'(src_y_q))
				|| (12'(dst_z_q) * 12'(zz) > 12'(src_z_q));
		end
	end

	logic cfg_wr, in_acc, out_acc;
	assign cfg_ready = (state_q == ST_IDLE) && !m_axis_tvalid;
	assign cfg_wr = cfg_valid && cfg_ready;
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	// Hold off requests in the cycle after a write so err_q catches up.
	logic cfg_wr_q;
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE) && !m_axis_tvalid && !cfg_wr_q
			&& !cfg_valid;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_acc && !err_q) state_d = ST_READ;
			ST_READ: state_d = (inside_s1 && last_s1) ? ST_DIV : ST_IDLE;
			ST_DIV: if (cnt_q == DivCntBits'(DivSteps)) state_d = ST_OUT;
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Issue the read on acceptance so the sum is ready in the read stage.
	assign rd_addr = AddrBits'(16'(by_q) * 16'(dst_x_q) + 16'(bx_q));

	logic [SumBits-1:0] sext;
	assign sext = {{(SumBits-SampleBits){sample_s1[SampleBits-1]}}, sample_s1};
	assign new_sum = first_s1 ? sext : rd_sum + sext;

	vbds_ram #(.Width(SumBits), .Depth(MaxDim * MaxDim)) u_sums (
		.clk(clk),
		.wr_en(state_q == ST_READ && inside_s1),
		.wr_addr(addr_s1),
		.wr_data(new_sum),
		.rd_addr(rd_addr),
		.rd_data(rd_sum)
	);

	logic [SumBits:0] trial;
	assign trial = {rem_q, quo_q[SumBits-1]} - {{(SumBits+1-DivBits){1'b0}}, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cfg_wr_q <= 1'b0;
			src_x_q <= 8'd128; src_y_q <= 8'd128; src_z_q <= 8'd128;
			dst_x_q <= 8'd64; dst_y_q <= 8'd64; dst_z_q <= 8'd64;
			zoom_q <= 12'd546;
			pos_x_q <= '0; pos_y_q <= '0; pos_z_q <= '0;
			rx_q <= '0; ry_q <= '0; rz_q <= '0;
			bx_q <= '0; by_q <= '0; bz_q <= '0;
			m_axis_tvalid <= 1'b0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cfg_wr_q <= cfg_wr;
			if (out_acc) m_axis_tvalid <= 1'b0;
			if (cfg_wr) begin
				case (cfg_index)
					REG_SRC_X: src_x_q <= cfg_data[7:0];
					REG_SRC_Y: src_y_q <= cfg_data[7:0];
					REG_SRC_Z: src_z_q <= cfg_data[7:0];
					REG_DST_X: dst_x_q <= cfg_data[7:0];
					REG_DST_Y: dst_y_q <= cfg_data[7:0];
					REG_DST_Z: dst_z_q <= cfg_data[7:0];
					REG_ZOOM: zoom_q <= cfg_data;
					default: ;
				endcase
				pos_x_q <= '0; pos_y_q <= '0; pos_z_q <= '0;
				rx_q <= '0; ry_q <= '0; rz_q <= '0;
				bx_q <= '0; by_q <= '0; bz_q <= '0;
			end
			if (in_acc && err_q) begin
				m_axis_tvalid <= 1'b1;
			end
			if (in_acc && !err_q) begin
				// advance raster position with box remainders
				if (9'(pos_x_q) + 9'd1 < 9'(src_x_q)) begin
					pos_x_q <= pos_x_q + 1'b1;
					if (rx_q == zx - 4'd1) begin
						rx_q <= '0; bx_q <= bx_q + 1'b1;
					end else rx_q <= rx_q + 4'd1;
				end else begin
					pos_x_q <= '0; rx_q <= '0; bx_q <= '0;
					if (9'(pos_y_q) + 9'd1 < 9'(src_y_q)) begin
						pos_y_q <= pos_y_q + 1'b1;
						if (ry_q == zy - 4'd1) begin
							ry_q <= '0; by_q <= by_q + 1'b1;
						end else ry_q <= ry_q + 4'd1;
					end else begin
						pos_y_q <= '0; ry_q <= '0; by_q <= '0;
						if (9'(pos_z_q) + 9'd1 < 9'(src_z_q)) begin
							pos_z_q <= pos_z_q + 1'b1;
							if (rz_q == zz - 4'd1) begin
								rz_q <= '0; bz_q <= bz_q + 1'b1;
							end else rz_q <= rz_q + 4'd1;
						end else begin
							pos_z_q <= '0; rz_q <= '0; bz_q <= '0;
						end
					end
				end
			end
			if (state_q == ST_READ) cnt_q <= '0;
			if (state_q == ST_DIV) cnt_q <= cnt_q + 1'b1;
			if (state_q == ST_OUT) m_axis_tvalid <= 1'b1;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_s1 <= s_axis_tdata[SampleBits-1:0];
			first_s1 <= rx_q == 4'd0 && ry_q == 4'd0 && rz_q == 4'd0;
			last_s1 <= rx_q == zx - 4'd1 && ry_q == zy - 4'd1 && rz_q == zz - 4'd1;
			inside_s1 <= 9'(bx_q) < 9'(dst_x_q) && 9'(by_q) < 9'(dst_y_q)
				&& 9'(bz_q) < 9'(dst_z_q);
			vol_last_s1 <= 9'(bx_q) == 9'(dst_x_q) - 9'd1
				&& 9'(by_q) == 9'(dst_y_q) - 9'd1 && 9'(bz_q) == 9'(dst_z_q) - 9'd1;
			addr_s1 <= rd_addr;
			if (err_q) begin
				avg_q <= '0; tlast_q <= 1'b0; tuser_q <= 1'b1;
			end
		end
		if (state_q == ST_READ) begin
			neg_q <= new_sum[SumBits-1];
			quo_q <= new_sum[SumBits-1] ? -new_sum : new_sum;
			rem_q <= '0;
			div_q <= DivBits'(zx) * DivBits'(zy) * DivBits'(zz);
			tlast_q <= vol_last_s1;
			tuser_q <= 1'b0;
		end
		if (state_q == ST_DIV && cnt_q != DivCntBits'(DivSteps)) begin
			if (!trial[SumBits]) rem_q <= trial[SumBits-1:0];
			else rem_q <= {rem_q[SumBits-2:0], quo_q[SumBits-1]};
			quo_q <= {quo_q[SumBits-2:0], !trial[SumBits]};
		end
		if (state_q == ST_OUT) begin
			avg_q <= neg_q ? SampleBits'(-quo_q) : SampleBits'(quo_q);
		end
	end

	assign m_axis_tdata = TdBits'(avg_q);
	assign m_axis_tlast = tlast_q;
	assign m_axis_tuser = tuser_q;
endmodule

// ===== sv/vbds_checker.sv =====
// Port-level checker for volume_box_downsample_unit, bound to the top level.
// Depends on vbds_pkg.
module vbds_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic m_axis_tlast,
	input logic m_axis_tuser,
	input logic cfg_valid,
	input logic cfg_ready
);
	import vbds_pkg::*;

	// No new request is taken while a result waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input taken with result pending");

	// Error results never mark volume end.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> !m_axis_tlast)
		else $error("error result with tlast");

	// Results hold until taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tlast))
		else $error("result dropped");

	// Config and input never accepted together.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cfg_valid && cfg_ready && s_axis_tvalid && s_axis_tready))
		else $error("config and input in the same cycle");
endmodule

bind volume_box_downsample_unit vbds_checker u_vbds_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tlast(m_axis_tlast),
	.m_axis_tuser(m_axis_tuser),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);

// ===== verif/tb_volume_box_downsample_unit.sv =====
// Testbench for volume_box_downsample_unit: streams voxel volumes under many box
// configurations and checks every average, last flag and error flag against a predictor.
// Depends on vbds_pkg and the unit RTL.
module tb_volume_box_downsample_unit;
	import vbds_pkg::*;

	localparam int unsigned DimMax = 128;
	localparam int unsigned ZoomMax = 8;
	localparam int unsigned DrainCycles = 60;
	localparam int ItemTarget = 950;
	localparam longint unsigned CycleLimit = 3000000;
	localparam logic [CfgIndexBits-1:0] REG_NONE = 3'd7;

	typedef struct packed {
		logic [23:0] average;
		logic last_of_volume;
		logic config_error;
	} pool_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic m_axis_tlast;
	logic m_axis_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIndexBits-1:0] cfg_index = '0;
	logic [CfgDataBits-1:0] cfg_data = '0;

	// shadow of the block: registers, accumulator plane and position
	logic [7:0] src_x, src_y, src_z, dst_x, dst_y, dst_z;
	logic [11:0] zoom_reg;
	longint plane_sums [DimMax*DimMax];
	int unsigned at_x, at_y, at_z;

	pool_result_t pending_averages[$];
	int error_count = 0;
	longint unsigned cycle_count = 0;
	bit stall_enable = 1'b1;
	int voxels_sent = 0;

	volume_box_downsample_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("tb_volume_box_downsample_unit: errors");
			$finish;
		end
	end

	task automatic report(input string what);
		error_count++;
		$display("MISMATCH at cycle %0d: %s", cycle_count, what);
	endtask

	function automatic bit dim_bad(input logic [7:0] n);
		return n == 0 || n > DimMax;
	endfunction

	// on a bad config queue only an error result, else advance one voxel and queue any average
	task automatic pool_voxel(input logic [23:0] sample);
		int unsigned zx, zy, zz, bx, by, bz, rx, ry, rz, slot;
		bit bad;
		pool_result_t res;
		zx = zoom_reg[3:0];
		zy = zoom_reg[7:4];
		zz = zoom_reg[11:8];
		bad = dim_bad(src_x) || dim_bad(src_y) || dim_bad(src_z) || dim_bad(dst_x) ||
			dim_bad(dst_y) || dim_bad(dst_z) || zx == 0 || zx > ZoomMax ||
			zy == 0 || zy > ZoomMax || zz == 0 || zz > ZoomMax;
		if (!bad)
			bad = dst_x * zx > src_x || dst_y * zy > src_y || dst_z * zz > src_z;
		if (bad) begin
			res.average = '0;
			res.last_of_volume = 1'b0;
			res.config_error = 1'b1;
			pending_averages.push_back(res);
			return;
		end
		bx = at_x / zx; by = at_y / zy; bz = at_z / zz;
		rx = at_x % zx; ry = at_y % zy; rz = at_z % zz;
		if (bx < dst_x && by < dst_y && bz < dst_z) begin
			slot = by * dst_x + bx;
			if (rx == 0 && ry == 0 && rz == 0)
				plane_sums[slot] = longint'($signed(sample));
			else
				plane_sums[slot] += longint'($signed(sample));
			if (rx == zx - 1 && ry == zy - 1 && rz == zz - 1) begin
				res.average = 24'(plane_sums[slot] / longint'(zx * zy * zz));
				res.last_of_volume = bx == dst_x - 1 && by == dst_y - 1 && bz == dst_z - 1;
				res.config_error = 1'b0;
				pending_averages.push_back(res);
			end
		end
		if (at_x + 1 < src_x) begin
			at_x++;
		end else begin
			at_x = 0;
			if (at_y + 1 < src_y) begin
				at_y++;
			end else begin
				at_y = 0;
				at_z = (at_z + 1 < src_z) ? at_z + 1 : 0;
			end
		end
	endtask

	// hold the request until taken; valid stays high for the next item
	task automatic send_voxel(input logic [23:0] sample);
		if (stall_enable && $urandom_range(99) < 38) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 38);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= sample;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		pool_voxel(sample);
		voxels_sent++;
	endtask

	// caller lowers cfg_valid after the last write of a group
	task automatic write_reg(input logic [CfgIndexBits-1:0] idx, input logic [11:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		case (idx)
			REG_SRC_X: src_x = value[7:0];
			REG_SRC_Y: src_y = value[7:0];
			REG_SRC_Z: src_z = value[7:0];
			REG_DST_X: dst_x = value[7:0];
			REG_DST_Y: dst_y = value[7:0];
			REG_DST_Z: dst_z = value[7:0];
			REG_ZOOM: zoom_reg = value;
			default: ;
		endcase
		at_x = 0; at_y = 0; at_z = 0;
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_averages.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic program_volume(input int sx, sy, sz, dx, dy, dz, input logic [11:0] zoom);
		wait_idle();
		write_reg(REG_SRC_X, 12'(sx));
		write_reg(REG_SRC_Y, 12'(sy));
		write_reg(REG_SRC_Z, 12'(sz));
		write_reg(REG_DST_X, 12'(dx));
		write_reg(REG_DST_Y, 12'(dy));
		write_reg(REG_DST_Z, 12'(dz));
		write_reg(REG_ZOOM, zoom);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [23:0] pick_sample();
		case ($urandom_range(9))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic send_volume(input int count);
		for (int i = 0; i < count; i++)
			send_voxel(pick_sample());
	endtask

	always @(posedge clk) begin
		pool_result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_averages.size() == 0) begin
				report("result with nothing expected");
			end else begin
				want = pending_averages.pop_front();
				if (m_axis_tdata !== want.average)
					report($sformatf("average %h, expected %h", m_axis_tdata, want.average));
				if (m_axis_tlast !== want.last_of_volume)
					report($sformatf("tlast %b, expected %b", m_axis_tlast,
						want.last_of_volume));
				if (m_axis_tuser !== want.config_error)
					report($sformatf("config_error %b, expected %b", m_axis_tuser,
						want.config_error));
			end
		end
		m_axis_tready <= stall_enable ? ($urandom_range(99) >= 38) : 1'b1;
	end

	// reset config is legal but huge: a few voxels, never completing a box
	task automatic test_reset_defaults();
		for (int i = 0; i < 6; i++)
			send_voxel(pick_sample());
	endtask

	task automatic test_bad_configs();
		program_volume(4, 4, 4, 2, 2, 2, 12'h000);
		send_volume(2);
		program_volume(4, 4, 4, 2, 2, 2, 12'hFFF);
		send_volume(2);
		program_volume(4, 4, 4, 2, 2, 2, 12'h922);
		send_volume(2);
		program_volume(0, 4, 4, 1, 1, 1, 12'h111);
		send_volume(2);
		program_volume(255, 255, 255, 129, 1, 1, 12'h111);
		send_volume(2);
		program_volume(4, 4, 3, 2, 2, 2, 12'h222);
		send_volume(2);
	endtask

	task automatic test_extremes();
		program_volume(2, 2, 2, 1, 1, 1, 12'h222);
		for (int i = 0; i < 8; i++)
			send_voxel(24'h7FFFFF);
		for (int i = 0; i < 8; i++)
			send_voxel(24'h800000);
		// uneven sums truncate toward zero; x beyond the region is dropped
		program_volume(3, 1, 1, 1, 1, 1, 12'h112);
		send_voxel(24'hFFFFFD);
		send_voxel(24'h000000);
		send_voxel(24'h555555);
		program_volume(128, 1, 1, 16, 1, 1, 12'h118);
		send_volume(8);
	endtask

	// a write past the register list only restarts the volume
	task automatic test_restart_write();
		program_volume(2, 2, 2, 1, 1, 1, 12'h222);
		send_volume(5);
		wait_idle();
		write_reg(REG_NONE, 12'hAAA);
		cfg_valid <= 1'b0;
		send_volume(8);
	endtask

	task automatic test_random_volumes();
		int dx, dy, dz, zx, zy, zz, sx, sy, sz, vol;
		while (voxels_sent < ItemTarget) begin
			stall_enable = !(voxels_sent > 500 && voxels_sent < 650);
			if ($urandom_range(19) == 0) begin
				dx = 1; dy = 1; dz = 1; zx = 8; zy = 8; zz = 8;
			end else begin
				dx = $urandom_range(1, 3); dy = $urandom_range(1, 2); dz = $urandom_range(1, 2);
				zx = $urandom_range(1, 3); zy = $urandom_range(1, 3); zz = $urandom_range(1, 2);
			end
			sx = dx * zx + $urandom_range(0, 1);
			sy = dy * zy + $urandom_range(0, 1);
			sz = dz * zz + $urandom_range(0, 1);
			if ($urandom_range(15) == 0)
				sx = dx * zx - 1;
			program_volume(sx, sy, sz, dx, dy, dz, 12'(zz << 8 | zy << 4 | zx));
			vol = sx * sy * sz;
			if (vol == 0 || $urandom_range(9) == 0)
				vol = $urandom_range(1, 6);
			else if ($urandom_range(4) == 0)
				vol = vol * 2;
			// trim the last volume to the item budget
			if (vol > ItemTarget - voxels_sent)
				vol = ItemTarget - voxels_sent;
			send_volume(vol);
		end
		stall_enable = 1'b1;
	endtask

	initial begin
		src_x = 128; src_y = 128; src_z = 128;
		dst_x = 64; dst_y = 64; dst_z = 64;
		zoom_reg = 12'h222;
		at_x = 0; at_y = 0; at_z = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_bad_configs();
		test_extremes();
		test_restart_write();
		test_random_volumes();
		wait_idle();
		if (error_count == 0)
			$display("tb_volume_box_downsample_unit: clean");
		else
			$display("tb_volume_box_downsample_unit: errors");
		$finish;
	end

endmodule

// ===== volume_box_downsample_unit.f =====
sv/vbds_pkg.sv
sv/vbds_ram.sv
sv/volume_box_downsample_unit.sv
sv/vbds_checker.sv
verif/tb_volume_box_downsample_unit.sv
